// File: rtl/core/lseg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lseg_pkg;

    localparam int NUM_PIXELS = 16;
    localparam int IDX_W      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

    localparam logic [IDX_W-1:0] LAST_PIX     = IDX_W'(NUM_PIXELS - 1);
    localparam logic [6:0]       NUM_PIXELS_7 = 7'(NUM_PIXELS);

    localparam logic [2:0] MODE_WIPE    = 3'd0;
    localparam logic [2:0] MODE_RAINBOW = 3'd1;
    localparam logic [2:0] MODE_CYCLE   = 3'd2;
    localparam logic [2:0] MODE_CHASE   = 3'd3;
    localparam logic [2:0] MODE_THEATER = 3'd4;

    localparam logic [2:0] REG_EFFECT_MODE = 3'd0;
    localparam logic [2:0] REG_FILL_COLOR  = 3'd1;
    localparam logic [2:0] REG_FRAME_WAIT  = 3'd2;
    localparam logic [2:0] REG_RANGE_START = 3'd3;
    localparam logic [2:0] REG_RANGE_STOP  = 3'd4;
    localparam logic [2:0] REG_WHOLE_STRIP = 3'd5;

    localparam logic [10:0] FRAMES_RAINBOW = 11'd256;
    localparam logic [10:0] FRAMES_CYCLE   = 11'd1280;
    localparam logic [10:0] FRAMES_CHASE   = 11'd30;
    localparam logic [10:0] FRAMES_THEATER = 11'd768;

    localparam logic [7:0] WHEEL_SEG1 = 8'd85;
    localparam logic [7:0] WHEEL_SEG2 = 8'd170;
    localparam logic [8:0] WHEEL_MOD  = 9'd255;

    localparam int DIV_DVD_W = 14;
    localparam int DIV_CNT_W = 4;

    typedef struct packed {
        logic [2:0]  mode;
        logic [23:0] fill;
        logic [5:0]  lo;
        logic [6:0]  hi;
        logic [10:0] frame;
        logic [7:0]  j;
        logic [1:0]  q;
        logic [6:0]  base;
    } lseg_ctx_t;

    function automatic logic [23:0] lseg_wheel(input logic [7:0] pos);
        logic [7:0]  t;
        logic [9:0]  t10;
        logic [7:0]  t3;
        logic [23:0] res;
        if (pos < WHEEL_SEG1)
        begin
            t = pos;
        end
        else if (pos < WHEEL_SEG2)
        begin
            t = pos - WHEEL_SEG1;
        end
        else
        begin
            t = pos - WHEEL_SEG2;
        end
        t10 = {2'b00, t} + {1'b0, t, 1'b0};
        t3  = t10[7:0];
        if (pos < WHEEL_SEG1)
        begin
            res = {t3, ~t3, 8'h00};
        end
        else if (pos < WHEEL_SEG2)
        begin
            res = {~t3, 8'h00, t3};
        end
        else
        begin
            res = {8'h00, t3, ~t3};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lseg_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lseg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/lseg_div.sv
`timescale 1ns / 1ps
`default_nettype none

module lseg_div
    import lseg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [DIV_DVD_W-1:0] dividend,
    input  wire logic [7:0]           divisor,
    output logic                      busy,
    output logic      [7:0]           quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_DVD_W-1:0] dvd_reg, dvd_next;
    logic [7:0]           rem_reg, rem_next;
    logic [7:0]           dsr_reg, dsr_next;
    logic [7:0]           quo_reg, quo_next;
    logic [8:0]           trial;
    logic                 fits;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DIV_DVD_W-1]};
        fits      = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_DVD_W);
            dvd_next  = dividend;
            rem_next  = 8'h00;
            dsr_next  = divisor;
            quo_next  = 8'h00;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? 8'(trial - {1'b0, dsr_reg}) : trial[7:0];
            dvd_next = {dvd_reg[DIV_DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[6:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/lseg_pixel.sv
`timescale 1ns / 1ps
`default_nettype none

module lseg_pixel
    import lseg_pkg::*;
(
    input  wire lseg_ctx_t   ctx,
    input  wire logic [5:0]  pix,
    input  wire logic [1:0]  phase,
    input  wire logic [7:0]  cycle_pos,
    input  wire logic [23:0] old_color,
    output logic      [23:0] emit_color,
    output logic      [23:0] store_color
);

    logic [6:0]  p7;
    logic [11:0] wipe_pos;
    logic        in_range;
    logic        theater_hit;
    logic [6:0]  chase_i;
    logic [8:0]  chase_sum;
    logic [8:0]  chase_pos;
    logic        drawn;
    logic        theater;
    logic [23:0] color;

    always_comb
    begin
        p7          = {1'b0, pix};
        wipe_pos    = {6'b0, ctx.lo} + {1'b0, ctx.frame};
        in_range    = (p7 >= {1'b0, ctx.lo}) && (p7 < ctx.hi);
        theater_hit = (p7 >= ctx.base)
                    && ({1'b0, p7} < ({1'b0, ctx.hi} + {6'b0, ctx.q}))
                    && (phase == 2'd0);
        chase_i     = p7 - {5'b0, ctx.q};
        chase_sum   = {2'b0, chase_i} + {1'b0, ctx.j};
        chase_pos   = (chase_sum >= WHEEL_MOD) ? chase_sum - WHEEL_MOD : chase_sum;
        theater     = 1'b0;
        unique case (ctx.mode)
            MODE_WIPE:
            begin
                drawn = ({6'b0, pix} == wipe_pos);
                color = ctx.fill;
            end
            MODE_RAINBOW:
            begin
                drawn = in_range;
                color = lseg_wheel({2'b0, pix} + ctx.frame[7:0]);
            end
            MODE_CYCLE:
            begin
                drawn = in_range;
                color = lseg_wheel(cycle_pos + ctx.frame[7:0]);
            end
            MODE_CHASE:
            begin
                drawn   = theater_hit;
                theater = 1'b1;
                color   = ctx.fill;
            end
            MODE_THEATER:
            begin
                drawn   = theater_hit;
                theater = 1'b1;
                color   = lseg_wheel(chase_pos[7:0]);
            end
            default:
            begin
                drawn = 1'b0;
                color = ctx.fill;
            end
        endcase
        emit_color  = drawn ? color : old_color;
        store_color = drawn ? (theater ? 24'h000000 : color) : old_color;
    end

endmodule

`default_nettype wire

// File: rtl/core/led_strip_effect_generator.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake               | payload
// ---------+-------------------------+--------------------------------------------
// in       | in_valid / in_ready     | restart
// out      | out_valid / out_ready   | pixel_index, pixel_color, last_of_frame,
//          |                         | effect_done
// cfg      | cfg_valid / cfg_ready   | cfg_index (3), cfg_data (24)
//
// A tick that emits nothing stays in the accept step. A tick that draws a frame
// goes through the accept step, the SETUP and BASE steps, then a read and an
// emit of the pixel store RAM per pixel (read, the 14-step divider, emit per
// pixel in rainbow cycle mode). Reset clears the counters and the per-pixel
// valid bits and sets the config registers to their defaults; the store reads
// as zero until written. A stalled output holds the emit step.

module led_strip_effect_generator
    import lseg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [5:0]  pixel_index,
    output logic      [23:0] pixel_color,
    output logic             last_of_frame,
    output logic             effect_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_BASE  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    localparam logic [9:0] RECIP3_11 = 10'd683;
    localparam logic [5:0] RECIP3_7  = 6'd43;

    logic [2:0]            state_reg, state_next;
    logic [2:0]            mode_reg;
    logic [23:0]           fill_reg;
    logic [7:0]            wait_cfg_reg;
    logic [5:0]            start_reg;
    logic [6:0]            stop_reg;
    logic                  whole_reg;
    logic [10:0]           frame_reg, frame_next;
    logic [7:0]            wait_reg, wait_next;
    logic                  finished_reg, finished_next;
    logic                  done_reg, done_next;
    logic [IDX_W-1:0]      pix_reg, pix_next;
    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            j_reg, j_next;
    logic [1:0]            q_reg, q_next;
    logic [6:0]            base_reg, base_next;
    logic                  out_valid_reg, out_valid_next;
    logic [NUM_PIXELS-1:0] valid_reg, valid_next;
    logic [5:0]            out_index_reg;
    logic [23:0]           out_color_reg;
    logic                  out_last_reg;
    logic                  out_done_reg;

    logic [5:0]  lo;
    logic [6:0]  hi;
    logic [10:0] total;
    logic [10:0] f_eff;
    logic [20:0] f_prod;
    logic [9:0]  f_third;
    logic [11:0] f_three;
    logic [6:0]  base_sum;
    logic [12:0] base_prod;
    logic [5:0]  base_third;
    logic [7:0]  base_three;
    logic [7:0]  base_rem;
    logic [5:0]  pix6;
    logic [7:0]  divisor;
    logic        emit_load;
    logic        ram_we;
    logic        ram_re;
    logic        div_start;
    logic        div_busy;
    logic [7:0]  div_quo;
    logic [23:0] ram_rdata;
    logic [23:0] old_color;
    logic [23:0] emit_color;
    logic [23:0] store_color;
    lseg_ctx_t   ctx;

    assign lo   = whole_reg ? 6'd0 : start_reg;
    assign hi   = whole_reg ? NUM_PIXELS_7 : stop_reg;
    assign pix6 = 6'(pix_reg);

    always_comb
    begin
        unique case (mode_reg)
            MODE_WIPE:    total = (hi > {1'b0, lo}) ? 11'(hi - {1'b0, lo}) : 11'd0;
            MODE_RAINBOW: total = FRAMES_RAINBOW;
            MODE_CYCLE:   total = FRAMES_CYCLE;
            MODE_CHASE:   total = FRAMES_CHASE;
            MODE_THEATER: total = FRAMES_THEATER;
            default:      total = 11'd0;
        endcase
    end

    assign divisor = whole_reg ? 8'(NUM_PIXELS)
                               : 8'({1'b0, hi} - {2'b0, lo} + 8'd1);

    assign f_eff      = restart ? 11'd0 : frame_reg;
    assign f_prod     = 21'(frame_reg) * 21'(RECIP3_11);
    assign f_third    = f_prod[20:11];
    assign f_three    = {2'b0, f_third} + {1'b0, f_third, 1'b0};
    assign base_sum   = {1'b0, lo} + {5'b0, q_reg};
    assign base_prod  = 13'(base_sum) * 13'(RECIP3_7);
    assign base_third = base_prod[12:7];
    assign base_three = {2'b0, base_third} + {1'b0, base_third, 1'b0};
    assign base_rem   = {1'b0, base_sum} - base_three;

    assign old_color = valid_reg[pix_reg] ? ram_rdata : 24'h000000;

    assign ctx.mode  = mode_reg;
    assign ctx.fill  = fill_reg;
    assign ctx.lo    = lo;
    assign ctx.hi    = hi;
    assign ctx.frame = frame_reg;
    assign ctx.j     = j_reg;
    assign ctx.q     = q_reg;
    assign ctx.base  = base_reg;

    always_comb
    begin
        state_next     = state_reg;
        frame_next     = frame_reg;
        wait_next      = wait_reg;
        finished_next  = finished_reg;
        done_next      = done_reg;
        pix_next       = pix_reg;
        phase_next     = phase_reg;
        j_next         = j_reg;
        q_next         = q_reg;
        base_next      = base_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        emit_load      = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        div_start      = 1'b0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        frame_next    = 11'd0;
                        wait_next     = 8'd0;
                        finished_next = 1'b0;
                    end
                    priority if (!restart && finished_reg)
                    begin
                        finished_next = 1'b1;
                    end
                    else if (!restart && (wait_reg != 8'd0))
                    begin
                        wait_next = wait_reg - 8'd1;
                    end
                    else if (f_eff >= total)
                    begin
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        done_next  = ({1'b0, f_eff} + 12'd1) >= {1'b0, total};
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                j_next     = f_third[7:0];
                q_next     = 2'(frame_reg - f_three[10:0]);
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                base_next  = base_sum;
                phase_next = (base_rem[1:0] == 2'd0) ? 2'd0 : 2'(2'd3 - base_rem[1:0]);
                pix_next   = '0;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
                if (mode_reg == MODE_CYCLE)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    emit_load           = 1'b1;
                    out_valid_next      = 1'b1;
                    ram_we              = 1'b1;
                    valid_next[pix_reg] = 1'b1;
                    phase_next          = (phase_reg == 2'd2) ? 2'd0 : phase_reg + 2'd1;
                    if (pix_reg == LAST_PIX)
                    begin
                        frame_next    = frame_reg + 11'd1;
                        wait_next     = wait_cfg_reg;
                        finished_next = done_reg;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        pix_next   = pix_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_WIPE;
            fill_reg      <= 24'h000000;
            wait_cfg_reg  <= 8'd0;
            start_reg     <= 6'd0;
            stop_reg      <= 7'd16;
            whole_reg     <= 1'b1;
            frame_reg     <= 11'd0;
            wait_reg      <= 8'd0;
            finished_reg  <= 1'b0;
            done_reg      <= 1'b0;
            pix_reg       <= '0;
            phase_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            frame_reg     <= frame_next;
            wait_reg      <= wait_next;
            finished_reg  <= finished_next;
            done_reg      <= done_next;
            pix_reg       <= pix_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_EFFECT_MODE: mode_reg     <= cfg_data[2:0];
                    REG_FILL_COLOR:  fill_reg     <= cfg_data;
                    REG_FRAME_WAIT:  wait_cfg_reg <= cfg_data[7:0];
                    REG_RANGE_START: start_reg    <= cfg_data[5:0];
                    REG_RANGE_STOP:  stop_reg     <= cfg_data[6:0];
                    REG_WHOLE_STRIP: whole_reg    <= cfg_data[0];
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        q_reg    <= q_next;
        base_reg <= base_next;
        if (emit_load)
        begin
            out_index_reg <= pix6;
            out_color_reg <= emit_color;
            out_last_reg  <= (pix_reg == LAST_PIX);
            out_done_reg  <= done_reg;
        end
    end

    lseg_ram #(
        .WIDTH (24),
        .DEPTH (NUM_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pix_reg),
        .wdata (store_color),
        .re    (ram_re),
        .raddr (pix_reg),
        .rdata (ram_rdata)
    );

    lseg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({pix6, 8'h00}),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    lseg_pixel u_pixel (
        .ctx         (ctx),
        .pix         (pix6),
        .phase       (phase_reg),
        .cycle_pos   (div_quo),
        .old_color   (old_color),
        .emit_color  (emit_color),
        .store_color (store_color)
    );

    assign in_ready      = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign pixel_index   = out_index_reg;
    assign pixel_color   = out_color_reg;
    assign last_of_frame = out_last_reg;
    assign effect_done   = out_done_reg;

endmodule

`default_nettype wire

// File: tb/sv/led_strip_effect_generator_tb.sv
`timescale 1ns / 1ps

import lseg_pkg::*;

typedef struct {
    logic [5:0]  idx;
    logic [23:0] color;
    logic        last;
    logic        done;
} pixel_t;

class strip_scoreboard;
    logic [2:0]  mode;
    logic [23:0] fill;
    logic [7:0]  wait_ticks;
    logic [5:0]  rstart;
    logic [6:0]  rstop;
    logic        whole;

    logic [23:0] store [NUM_PIXELS];
    logic [10:0] frame_cnt;
    logic [7:0]  wait_cnt;
    logic        done_flag;

    pixel_t      pixels_due [$];
    int          errors;

    function new();
        mode       = MODE_WIPE;
        fill       = 24'h000000;
        wait_ticks = 8'd0;
        rstart     = 6'd0;
        rstop      = 7'd16;
        whole      = 1'b1;
        foreach (store[k])
            store[k] = 24'h000000;
        frame_cnt  = 11'd0;
        wait_cnt   = 8'd0;
        done_flag  = 1'b0;
        errors     = 0;
    endfunction

    function void set_reg(input logic [2:0] idx, input logic [23:0] val);
        case (idx)
            REG_EFFECT_MODE: mode       = val[2:0];
            REG_FILL_COLOR:  fill       = val;
            REG_FRAME_WAIT:  wait_ticks = val[7:0];
            REG_RANGE_START: rstart     = val[5:0];
            REG_RANGE_STOP:  rstop      = val[6:0];
            REG_WHOLE_STRIP: whole      = val[0];
            default: ;
        endcase
    endfunction

    function logic [23:0] color_wheel(input int unsigned pos);
        int unsigned p;
        int unsigned t3;
        p = pos & 255;
        if (p < 85)
        begin
            t3 = p * 3;
            return 24'((t3 << 16) | ((255 - t3) << 8));
        end
        else if (p < 170)
        begin
            t3 = (p - 85) * 3;
            return 24'(((255 - t3) << 16) | t3);
        end
        t3 = (p - 170) * 3;
        return 24'((t3 << 8) | (255 - t3));
    endfunction

    function void set_pixel(input int unsigned i, input logic [23:0] c);
        if (i < NUM_PIXELS)
            store[i] = c;
    endfunction

    function int unsigned frame_total(input int unsigned lo, input int unsigned hi);
        case (mode)
            MODE_WIPE:    return (hi > lo) ? hi - lo : 0;
            MODE_RAINBOW: return 32'(FRAMES_RAINBOW);
            MODE_CYCLE:   return 32'(FRAMES_CYCLE);
            MODE_CHASE:   return 32'(FRAMES_CHASE);
            MODE_THEATER: return 32'(FRAMES_THEATER);
            default:      return 0;
        endcase
    endfunction

    function void note_tick(input logic rs);
        int unsigned lo;
        int unsigned hi;
        int unsigned total;
        int unsigned f;
        int unsigned i;
        int unsigned dv;
        int unsigned q;
        pixel_t      px;
        if (rs)
        begin
            frame_cnt = 11'd0;
            wait_cnt  = 8'd0;
            done_flag = 1'b0;
        end
        if (done_flag)
            return;
        if (wait_cnt > 0)
        begin
            wait_cnt = wait_cnt - 8'd1;
            return;
        end
        lo    = whole ? 0 : 32'(rstart);
        hi    = whole ? NUM_PIXELS : 32'(rstop);
        total = frame_total(lo, hi);
        f     = 32'(frame_cnt);
        if (f >= total)
        begin
            done_flag = 1'b1;
            return;
        end
        q = f % 3;
        case (mode)
            MODE_WIPE:
                set_pixel(lo + f, fill);
            MODE_RAINBOW:
                for (i = lo; i < hi; i++)
                    set_pixel(i, color_wheel(i + f));
            MODE_CYCLE:
            begin
                dv = whole ? NUM_PIXELS : hi - lo + 1;
                if (lo < hi)
                    for (i = lo; i < hi; i++)
                        set_pixel(i, color_wheel((i * 256) / dv + f));
            end
            MODE_CHASE:
                for (i = lo; i < hi; i += 3)
                    set_pixel(i + q, fill);
            default:
                for (i = lo; i < hi; i += 3)
                    set_pixel(i + q, color_wheel((i + f / 3) % 255));
        endcase
        for (int p = 0; p < NUM_PIXELS; p++)
        begin
            px.idx   = 6'(p);
            px.color = store[p];
            px.last  = (p == NUM_PIXELS - 1);
            px.done  = (f + 1 >= total);
            pixels_due.push_back(px);
        end
        if (mode == MODE_CHASE || mode == MODE_THEATER)
            for (i = lo; i < hi; i += 3)
                set_pixel(i + q, 24'h000000);
        frame_cnt = 11'(f + 1);
        wait_cnt  = wait_ticks;
        if (f + 1 >= total)
            done_flag = 1'b1;
    endfunction

    function void check_pixel(input logic [5:0] idx, input logic [23:0] color,
                              input logic last, input logic done);
        pixel_t px;
        if (pixels_due.size() == 0)
        begin
            $display("%0t: unexpected pixel transfer index %0d color %06h", $time, idx, color);
            errors++;
            return;
        end
        px = pixels_due.pop_front();
        if (idx !== px.idx)
        begin
            $display("%0t: pixel_index expected %0d actual %0d", $time, px.idx, idx);
            errors++;
        end
        if (color !== px.color)
        begin
            $display("%0t: pixel_color expected %06h actual %06h (pixel %0d)",
                     $time, px.color, color, px.idx);
            errors++;
        end
        if (last !== px.last)
        begin
            $display("%0t: last_of_frame expected %0b actual %0b (pixel %0d)",
                     $time, px.last, last, px.idx);
            errors++;
        end
        if (done !== px.done)
        begin
            $display("%0t: effect_done expected %0b actual %0b (pixel %0d)",
                     $time, px.done, done, px.idx);
            errors++;
        end
    endfunction

    function int pending();
        return pixels_due.size();
    endfunction
endclass

module led_strip_effect_generator_tb;

    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_TICKS  = 380;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        restart = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [5:0]  pixel_index;
    logic [23:0] pixel_color;
    logic        last_of_frame;
    logic        effect_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = REG_EFFECT_MODE;
    logic [23:0] cfg_data = 24'h000000;

    int              send_idle_pct = 20;
    int              recv_idle_pct = 80;
    int              ticks_sent = 0;
    strip_scoreboard sb = new();

    led_strip_effect_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_index   (pixel_index),
        .pixel_color   (pixel_color),
        .last_of_frame (last_of_frame),
        .effect_done   (effect_done),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("** led_strip_effect_generator: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_pixel(pixel_index, pixel_color, last_of_frame, effect_done);
    end

    task automatic send_tick(input logic rs);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_tick(rs);
        ticks_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_burst(input int n, input logic first_rs, input int noise_pct);
        send_tick(first_rs);
        for (int k = 1; k < n; k++)
            send_tick($urandom_range(0, 99) < noise_pct);
        settle();
    endtask

    task automatic random_setup();
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_EFFECT_MODE, ($urandom_range(0, 15) == 0) ?
                      24'($urandom_range(5, 7)) : 24'($urandom_range(0, 4)));
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_FILL_COLOR, 24'($urandom));
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_FRAME_WAIT, ($urandom_range(0, 7) == 0) ?
                      24'($urandom_range(0, 255)) : 24'($urandom_range(0, 2)));
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_RANGE_START, ($urandom_range(0, 3) == 0) ?
                      24'($urandom_range(0, 63)) : 24'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_RANGE_STOP, ($urandom_range(0, 3) == 0) ?
                      24'($urandom_range(0, 64)) : 24'($urandom_range(0, 17)));
        if ($urandom_range(0, 2) != 0)
            write_reg(REG_WHOLE_STRIP, 24'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int random_base;
        int n;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wipe over the whole strip
        write_reg(REG_EFFECT_MODE, 24'(MODE_WIPE));
        write_reg(REG_FILL_COLOR, 24'hFFFFFF);
        write_reg(REG_FRAME_WAIT, 24'd0);
        write_reg(REG_RANGE_START, 24'd0);
        write_reg(REG_RANGE_STOP, 24'd64);
        write_reg(REG_WHOLE_STRIP, 24'd1);
        run_burst(3, 1'b1, 0);

        // rainbow with a frame wait
        write_reg(REG_EFFECT_MODE, 24'(MODE_RAINBOW));
        write_reg(REG_FRAME_WAIT, 24'd2);
        run_burst(4, 1'b1, 0);

        // rainbow cycle over a range
        write_reg(REG_EFFECT_MODE, 24'(MODE_CYCLE));
        write_reg(REG_FRAME_WAIT, 24'd0);
        write_reg(REG_RANGE_START, 24'd5);
        write_reg(REG_RANGE_STOP, 24'd9);
        write_reg(REG_WHOLE_STRIP, 24'd0);
        run_burst(2, 1'b1, 0);

        // chase running past the strip end
        write_reg(REG_EFFECT_MODE, 24'(MODE_CHASE));
        write_reg(REG_FILL_COLOR, 24'hA55A3C);
        write_reg(REG_RANGE_START, 24'd13);
        write_reg(REG_RANGE_STOP, 24'd64);
        run_burst(3, 1'b1, 0);

        // theater rainbow, longest wait
        write_reg(REG_EFFECT_MODE, 24'(MODE_THEATER));
        write_reg(REG_FRAME_WAIT, 24'd255);
        write_reg(REG_WHOLE_STRIP, 24'd1);
        run_burst(2, 1'b1, 0);

        // empty range still emits the store
        write_reg(REG_EFFECT_MODE, 24'(MODE_RAINBOW));
        write_reg(REG_FRAME_WAIT, 24'd0);
        write_reg(REG_RANGE_START, 24'd63);
        write_reg(REG_RANGE_STOP, 24'd0);
        write_reg(REG_WHOLE_STRIP, 24'd0);
        run_burst(1, 1'b1, 0);

        // short wipe runs to its end and then goes quiet
        write_reg(REG_EFFECT_MODE, 24'(MODE_WIPE));
        write_reg(REG_FILL_COLOR, 24'h000000);
        write_reg(REG_RANGE_START, 24'd14);
        write_reg(REG_RANGE_STOP, 24'd16);
        run_burst(3, 1'b1, 0);

        // undefined modes have no frames
        write_reg(REG_EFFECT_MODE, 24'd5);
        run_burst(1, 1'b1, 0);
        write_reg(REG_EFFECT_MODE, 24'd7);
        run_burst(1, 1'b1, 0);

        // shrink the range under a running wipe
        write_reg(REG_EFFECT_MODE, 24'(MODE_WIPE));
        write_reg(REG_FILL_COLOR, 24'h00FF00);
        write_reg(REG_RANGE_START, 24'd0);
        write_reg(REG_RANGE_STOP, 24'd10);
        run_burst(1, 1'b1, 0);
        write_reg(REG_RANGE_STOP, 24'd1);
        run_burst(1, 1'b0, 0);

        random_base = ticks_sent;
        while (ticks_sent - random_base < RANDOM_TICKS)
        begin
            if (ticks_sent - random_base >= 2 * RANDOM_TICKS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (ticks_sent - random_base >= RANDOM_TICKS / 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 20;
            end
            random_setup();
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 40) : $urandom_range(3, 20);
            run_burst(n, $urandom_range(0, 3) != 0, 5);
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("** led_strip_effect_generator: PASSED **");
        else
            $display("** led_strip_effect_generator: FAILED **");
        $finish;
    end

endmodule
